// File: rtl/nss_pkg.sv
// Shared types, constants and the byte classifier of the NMEA sentence checker.
`default_nettype none
package nss_pkg;

    localparam int MAX_FIELDS = 16;
    localparam logic [3:0] FIELD_LIMIT = (MAX_FIELDS > 16) ? 4'd15 : 4'(MAX_FIELDS - 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } phase_t;

    // Classified input byte, as handed from front to back.
    typedef struct packed {
        logic [7:0] c;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       hex_ok;
        logic [3:0] hex_val;
    } item_t;

    // Handshake between front queue and back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } fwd_t;

    typedef struct packed {
        logic [7:0] field_char;
        logic [3:0] field_number;
        logic       is_field_char;
        logic       field_done;
        logic       sentence_done;
        logic       checksum_match;
        logic [7:0] checksum_calc;
        logic [7:0] checksum_recv;
        status_t    status;
    } result_t;

    function automatic item_t classify(input logic [7:0] c);
        item_t r;
        r.c         = c;
        r.is_dollar = (c == CH_DOLLAR);
        r.is_star   = (c == CH_STAR);
        r.is_comma  = (c == CH_COMMA);
        r.hex_ok    = 1'b1;
        r.hex_val   = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.hex_val = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r.hex_val = c[3:0] + 4'd9;
        end else begin
            r.hex_ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/nss_front.sv
// Front end: classifies received bytes and holds them in a short queue for the back end.
`default_nettype none
module nss_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    rx_byte,
    output logic               full,
    output nss_pkg::fwd_t      fwd,
    input  wire logic          fwd_pop
);
    import nss_pkg::*;

    item_t            mem [QDEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = fwd_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= classify(rx_byte);
        end
    end

    assign fwd.valid = (count_reg != '0);
    assign fwd.item  = mem[rd_ptr_reg];

endmodule
`default_nettype wire

// File: rtl/nss_back.sv
// Back end: sentence state machine, checksum tracking and the result queue.
`default_nettype none
module nss_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire nss_pkg::fwd_t fwd,
    output logic               fwd_pop,
    output logic               empty,
    input  wire logic          pop,
    output nss_pkg::result_t   head
);
    import nss_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [7:0]      xor_reg, xor_next;
    logic [3:0]      fcount_reg, fcount_next;
    logic [3:0]      hnib_reg, hnib_next;
    logic            ovf_reg, ovf_next;
    result_t         res;

    result_t         mem [QDEPTH];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]  count_reg, count_next;
    logic            do_pop;
    item_t           it;

    assign it      = fwd.item;
    assign do_pop  = pop && !empty;
    assign empty   = (count_reg == '0);
    // Take a beat when there is room now or the head leaves this cycle.
    assign fwd_pop = fwd.valid && ((count_reg != QCW'(QDEPTH)) || do_pop);

    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        fcount_next = fcount_reg;
        hnib_next   = hnib_reg;
        ovf_next    = ovf_reg;

        res                = '0;
        res.field_char     = it.c;
        res.status         = ST_OK;

        if (it.is_dollar)
        begin
            xor_next    = '0;
            fcount_next = '0;
            hnib_next   = '0;
            ovf_next    = 1'b0;
            phase_next  = PH_BODY;
        end
        else
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    res.field_number = fcount_reg;
                    if (it.is_star)
                    begin
                        res.field_done = 1'b1;
                        phase_next     = PH_HI;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ it.c;
                        if (it.is_comma)
                        begin
                            res.field_done = 1'b1;
                            if (fcount_reg >= FIELD_LIMIT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                fcount_next = fcount_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            res.is_field_char = 1'b1;
                        end
                    end
                    res.checksum_calc = xor_next;
                    res.status        = ovf_next ? ST_OVERFLOW : ST_OK;
                end
                PH_HI:
                begin
                    res.field_number  = fcount_reg;
                    res.checksum_calc = xor_reg;
                    if (!it.hex_ok)
                    begin
                        res.status = ST_BAD_DIGIT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        hnib_next         = it.hex_val;
                        res.checksum_recv = {it.hex_val, 4'd0};
                        res.status        = ovf_reg ? ST_OVERFLOW : ST_OK;
                        phase_next        = PH_LO;
                    end
                end
                PH_LO:
                begin
                    res.field_number  = fcount_reg;
                    res.checksum_calc = xor_reg;
                    res.sentence_done = 1'b1;
                    res.checksum_recv = {hnib_reg, 4'd0};
                    if (!it.hex_ok)
                    begin
                        res.status = ST_BAD_DIGIT;
                    end
                    else
                    begin
                        res.checksum_recv  = {hnib_reg, it.hex_val};
                        res.checksum_match = ({hnib_reg, it.hex_val} == xor_reg);
                        res.status         = ovf_reg ? ST_OVERFLOW : ST_OK;
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // Idle: echo only.
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (fwd_pop && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !fwd_pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= '0;
            fcount_reg <= '0;
            hnib_reg   <= '0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (fwd_pop)
            begin
                phase_reg  <= phase_next;
                xor_reg    <= xor_next;
                fcount_reg <= fcount_next;
                hnib_reg   <= hnib_next;
                ovf_reg    <= ovf_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_pop)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

    assign head = mem[rd_ptr_reg];

endmodule
`default_nettype wire

// File: rtl/nmea_sentence_splitter_checker.sv
// Top level of the NMEA 0183 sentence splitter and checksum checker.
//
// Input channel: drive rx_byte and raise push; the byte is taken on a clock edge
// where push is high and full is low. Every byte yields exactly one result.
// Result channel: while empty is low the oldest result sits on the result ports;
// it leaves on a clock edge where pop is high.
// Path: a taken byte is classified into a two-entry front queue, read by the
// sentence state machine and written to a two-entry result queue, whose oldest
// entry sits on the result ports.
// Throughput: one byte per cycle while pop keeps the result queue from filling,
// set by the update of the phase, XOR and field counter in the back end.
// Stall: if pop stays low, the result queue fills, the back end holds, then
// the front queue fills and full rises; no beat is lost or repeated.
// Reset: rst_n (async, active low) empties both queues and returns to idle,
// waiting for a dollar sign, with the checksum and field counter cleared.
`default_nettype none
module nmea_sentence_splitter_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       field_char,
    output logic [3:0]       field_number,
    output logic             is_field_char,
    output logic             field_done,
    output logic             sentence_done,
    output logic             checksum_match,
    output logic [7:0]       checksum_calc,
    output logic [7:0]       checksum_recv,
    output logic [1:0]       status
);
    import nss_pkg::*;

    fwd_t    fwd;
    logic    fwd_pop;
    result_t head;

    nss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .full    (full),
        .fwd     (fwd),
        .fwd_pop (fwd_pop)
    );

    nss_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fwd     (fwd),
        .fwd_pop (fwd_pop),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign field_char     = head.field_char;
    assign field_number   = head.field_number;
    assign is_field_char  = head.is_field_char;
    assign field_done     = head.field_done;
    assign sentence_done  = head.sentence_done;
    assign checksum_match = head.checksum_match;
    assign checksum_calc  = head.checksum_calc;
    assign checksum_recv  = head.checksum_recv;
    assign status         = head.status;

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_pop |-> fwd.valid)
        else $error("back end took a beat from an empty front queue");

    a_match_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && checksum_match) |-> sentence_done)
        else $error("checksum match reported outside sentence end");

    a_field_char_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_field_char) |-> (!field_done && !sentence_done && status != ST_BAD_DIGIT))
        else $error("field content flagged together with a delimiter or digit");

    a_full_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> fwd.valid)
        else $error("front queue full but reports no item");

endmodule
`default_nettype wire

// File: tb/nss_result_checker.sv
// Checker for the NMEA sentence checker: predicts every result beat and compares it.
module nss_result_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] rx_byte,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [7:0] field_char,
    input  wire logic [3:0] field_number,
    input  wire logic       is_field_char,
    input  wire logic       field_done,
    input  wire logic       sentence_done,
    input  wire logic       checksum_match,
    input  wire logic [7:0] checksum_calc,
    input  wire logic [7:0] checksum_recv,
    input  wire logic [1:0] status,
    output int              errors,
    output int              pending,
    output int              sentences,
    output int              sums_matched,
    output int              overflow_beats,
    output int              bad_digits
);
    import nss_pkg::*;

    phase_t     sent_phase;
    logic [7:0] xor_sum;
    logic [3:0] field_idx;
    logic [3:0] sum_high;
    logic       overflowed;

    result_t    expected_beats[$];

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b0, 4'(c - "0")};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b0, 4'(c - "A" + 8'd10)};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b0, 4'(c - "a" + 8'd10)};
        end
        return 5'h10;
    endfunction

    function automatic result_t split_byte(input logic [7:0] c);
        result_t    r;
        logic [4:0] v;
        r = '0;
        r.field_char = c;
        r.status = ST_OK;
        v = hex_digit(c);
        if (c == CH_DOLLAR)
        begin
            xor_sum = '0;
            field_idx = '0;
            sum_high = '0;
            overflowed = 1'b0;
            sent_phase = PH_BODY;
        end
        else if (sent_phase == PH_BODY)
        begin
            r.field_number = field_idx;
            if (c == CH_STAR)
            begin
                r.field_done = 1'b1;
                sent_phase = PH_HI;
            end
            else
            begin
                xor_sum = xor_sum ^ c;
                if (c == CH_COMMA)
                begin
                    r.field_done = 1'b1;
                    // hold the counter at its limit and flag the overflow
                    if (field_idx >= FIELD_LIMIT)
                        overflowed = 1'b1;
                    else
                        field_idx = field_idx + 4'd1;
                end
                else
                begin
                    r.is_field_char = 1'b1;
                end
            end
            r.checksum_calc = xor_sum;
            r.status = overflowed ? ST_OVERFLOW : ST_OK;
        end
        else if (sent_phase == PH_HI)
        begin
            r.field_number = field_idx;
            r.checksum_calc = xor_sum;
            if (v[4])
            begin
                // drop the sentence without closing it
                r.status = ST_BAD_DIGIT;
                sent_phase = PH_IDLE;
            end
            else
            begin
                sum_high = v[3:0];
                r.checksum_recv = {v[3:0], 4'h0};
                r.status = overflowed ? ST_OVERFLOW : ST_OK;
                sent_phase = PH_LO;
            end
        end
        else if (sent_phase == PH_LO)
        begin
            r.field_number = field_idx;
            r.checksum_calc = xor_sum;
            r.sentence_done = 1'b1;
            r.checksum_recv = {sum_high, 4'h0};
            if (v[4])
            begin
                r.status = ST_BAD_DIGIT;
            end
            else
            begin
                r.checksum_recv[3:0] = v[3:0];
                r.checksum_match = (r.checksum_recv == xor_sum);
                r.status = overflowed ? ST_OVERFLOW : ST_OK;
            end
            sent_phase = PH_IDLE;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            sent_phase = PH_IDLE;
            xor_sum = '0;
            field_idx = '0;
            sum_high = '0;
            overflowed = 1'b0;
            expected_beats.delete();
            errors = 0;
            pending = 0;
            sentences = 0;
            sums_matched = 0;
            overflow_beats = 0;
            bad_digits = 0;
        end
        else
        begin
            if (push && !full)
            begin
                e = split_byte(rx_byte);
                expected_beats.push_back(e);
                if (e.sentence_done)
                    sentences++;
                if (e.checksum_match)
                    sums_matched++;
                if (e.status == ST_OVERFLOW)
                    overflow_beats++;
                if (e.status == ST_BAD_DIGIT)
                    bad_digits++;
            end
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: field_char 0x%02h", field_char);
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    check_field("field_char", e.field_char, field_char);
                    check_field("field_number", 8'(e.field_number), 8'(field_number));
                    check_field("is_field_char", 8'(e.is_field_char), 8'(is_field_char));
                    check_field("field_done", 8'(e.field_done), 8'(field_done));
                    check_field("sentence_done", 8'(e.sentence_done), 8'(sentence_done));
                    check_field("checksum_match", 8'(e.checksum_match), 8'(checksum_match));
                    check_field("checksum_calc", e.checksum_calc, checksum_calc);
                    check_field("checksum_recv", e.checksum_recv, checksum_recv);
                    check_field("status", 8'(e.status), 8'(status));
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top: drives byte streams into the sentence checker and reports the verdict.
module tb;
    import nss_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] rx_byte = '0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] field_char;
    logic [3:0] field_number;
    logic       is_field_char;
    logic       field_done;
    logic       sentence_done;
    logic       checksum_match;
    logic [7:0] checksum_calc;
    logic [7:0] checksum_recv;
    logic [1:0] status;

    int errors;
    int pending;
    int sentences;
    int sums_matched;
    int overflow_beats;
    int bad_digits;

    bit steady = 1'b0;
    int bytes_sent = 0;

    nmea_sentence_splitter_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .field_char     (field_char),
        .field_number   (field_number),
        .is_field_char  (is_field_char),
        .field_done     (field_done),
        .sentence_done  (sentence_done),
        .checksum_match (checksum_match),
        .checksum_calc  (checksum_calc),
        .checksum_recv  (checksum_recv),
        .status         (status)
    );

    nss_result_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .field_char     (field_char),
        .field_number   (field_number),
        .is_field_char  (is_field_char),
        .field_done     (field_done),
        .sentence_done  (sentence_done),
        .checksum_match (checksum_match),
        .checksum_calc  (checksum_calc),
        .checksum_recv  (checksum_recv),
        .status         (status),
        .errors         (errors),
        .pending        (pending),
        .sentences      (sentences),
        .sums_matched   (sums_matched),
        .overflow_beats (overflow_beats),
        .bad_digits     (bad_digits)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Result side: stall at random except during the steady stretch.
    always @(negedge clk)
    begin
        pop <= steady || ($urandom_range(0, 99) >= 22);
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Leaves push high on return; the caller lowers it when the stream pauses.
    task automatic send_byte(input logic [7:0] b);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 22)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
               (b >= "a" && b <= "f") || b == CH_DOLLAR);
        return b;
    endfunction

    // Well-formed sentence with random content; some get a wrong sum,
    // a bad digit, or are cut short.
    task automatic send_sentence();
        int         n_fields;
        int         len;
        int         kind;
        logic [7:0] sum;
        logic [7:0] b;
        n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        sum = '0;
        send_byte(CH_DOLLAR);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
            begin
                send_byte(CH_COMMA);
                sum ^= CH_COMMA;
            end
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++)
            begin
                b = body_byte();
                send_byte(b);
                sum ^= b;
            end
        end
        if ($urandom_range(0, 19) == 0)
            return;
        send_byte(CH_STAR);
        kind = $urandom_range(0, 99);
        if (kind < 15)
            sum ^= 8'($urandom_range(1, 255));
        if (kind < 5)
        begin
            send_byte(non_hex_byte());
        end
        else if (kind < 10)
        begin
            send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
            send_byte(non_hex_byte());
        end
        else
        begin
            send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
            send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 4))
                0: send_byte(CH_STAR);
                1: send_byte(CH_COMMA);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        int unit_idx;
        unit_idx = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle bytes at both extremes, restart mid-body, lowercase match,
        // bad second digit, uppercase mismatch, field overflow with bad first digit.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$x$a,b*2f");
        send_text("$*0Z");
        send_text("$Q*A1");
        send_byte(CH_DOLLAR);
        repeat (16) send_byte(CH_COMMA);
        send_text("*G");

        while (bytes_sent < 600)
        begin
            steady = (unit_idx >= 10 && unit_idx < 18);
            if (unit_idx == 25)
            begin
                // hold the stream until every result has drained
                push <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            if ($urandom_range(0, 99) < 85)
                send_sentence();
            else
                send_noise();
            unit_idx++;
        end
        steady = 1'b0;
        push <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);

        $display("Sent %0d bytes: %0d sentences closed, %0d with matching sums.",
                 bytes_sent, sentences, sums_matched);
        $display("Beats with field overflow: %0d, bad checksum digits: %0d.",
                 overflow_beats, bad_digits);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
